### src/psm_pkg.sv
package psm_pkg;

	// Fixed-point formats
	localparam int FRAC_BITS = 16;
	localparam int ANG_BITS  = 24;
	localparam int UP_SHIFT  = ANG_BITS - FRAC_BITS;
	localparam int STEPS     = 24;
	localparam int SW        = $clog2(STEPS);

	// CORDIC datapath width (angles in degrees Q.24, vectors Q.30)
	localparam int AW = 36;

	// Shared multiply/divide unit widths
	localparam int MA = 35;
	localparam int MB = 26;
	localparam int PW = MA + MB;
	localparam int NW = 64;
	localparam int DW = 32;
	localparam int QW = 40;
	localparam int CW = $clog2(QW);

	// Unit coordinate width and map bound widths
	localparam int UW = 32;
	localparam int BW = 19 + UP_SHIFT;

	localparam logic signed [AW-1:0] CORDIC_K = 36'sd652032874;
	localparam logic signed [AW-1:0] DEG45    = 36'sd754974720;
	localparam logic signed [AW-1:0] DEG90    = 36'sd1509949440;
	localparam logic signed [AW-1:0] DEG180   = 36'sd3019898880;
	localparam logic signed [AW-1:0] DEG360   = 36'sd6039797760;
	localparam logic signed [AW-1:0] R_SAT    = 36'sd17179869184;

	localparam logic signed [20:0] RATIO_MAX = 21'sd524287;

	// Configuration register indexes
	localparam logic [2:0] REG_INVERSE = 3'd0;
	localparam logic [2:0] REG_TL_X    = 3'd1;
	localparam logic [2:0] REG_TL_Y    = 3'd2;
	localparam logic [2:0] REG_BR_X    = 3'd3;
	localparam logic [2:0] REG_BR_Y    = 3'd4;
	localparam logic [2:0] REG_YAW_OFS = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SAT    = 2'd1;
	localparam logic [1:0] ST_BOUNDS = 2'd2;

	typedef struct packed {
		logic start;
		logic vector;
	} cordic_cmd_t;

	typedef struct packed {
		logic start;
		logic div;
	} md_cmd_t;

	// atan(2^-i) in degrees Q.24
	function automatic logic [29:0] atan_deg(input logic [SW-1:0] i);
		logic [29:0] a;
		case (i)
			5'd0:    a = 30'd754974720;
			5'd1:    a = 30'd445687602;
			5'd2:    a = 30'd235489088;
			5'd3:    a = 30'd119537938;
			5'd4:    a = 30'd60000934;
			5'd5:    a = 30'd30029717;
			5'd6:    a = 30'd15018523;
			5'd7:    a = 30'd7509720;
			5'd8:    a = 30'd3754917;
			5'd9:    a = 30'd1877466;
			5'd10:   a = 30'd938734;
			5'd11:   a = 30'd469367;
			5'd12:   a = 30'd234684;
			5'd13:   a = 30'd117342;
			5'd14:   a = 30'd58671;
			5'd15:   a = 30'd29335;
			5'd16:   a = 30'd14668;
			5'd17:   a = 30'd7334;
			5'd18:   a = 30'd3667;
			5'd19:   a = 30'd1833;
			5'd20:   a = 30'd917;
			5'd21:   a = 30'd458;
			5'd22:   a = 30'd229;
			5'd23:   a = 30'd115;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

	// Wrap into [-180,180) and fold into [-90,90]; MSB flags a fold
	function automatic logic [AW:0] reduce_angle(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] r;
		logic neg;
		r = a;
		neg = 1'b0;
		if (r < -DEG180)
			r = r + DEG360;
		else if (r >= DEG180)
			r = r - DEG360;
		if (r > DEG90) begin
			r = r - DEG180;
			neg = 1'b1;
		end else if (r < -DEG90) begin
			r = r + DEG180;
			neg = 1'b1;
		end
		return {neg, r};
	endfunction

	// Clip a signed quotient to the ratio range; MSB flags saturation
	function automatic logic [20:0] clip_ratio(input logic signed [QW:0] q);
		logic [20:0] res;
		if (q > QW'(RATIO_MAX))
			res = {1'b1, RATIO_MAX[19:0]};
		else if (q < -(QW+1)'(RATIO_MAX))
			res = {1'b1, 20'(-RATIO_MAX)};
		else
			res = {1'b0, q[19:0]};
		return res;
	endfunction

endpackage

### src/psm_intf.sv
interface psm_fix_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] latitude;
	logic signed [24:0] longitude;
	logic signed [24:0] yaw;
	logic               yaw_valid;

	modport source(output valid, latitude, longitude, yaw, yaw_valid, input ready);
	modport sink(input valid, latitude, longitude, yaw, yaw_valid, output ready);
endinterface

interface psm_pos_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] h_ratio;
	logic signed [19:0] v_ratio;
	logic signed [25:0] heading;
	logic        [1:0]  status;

	modport source(output valid, h_ratio, v_ratio, heading, status, input ready);
	modport sink(input valid, h_ratio, v_ratio, heading, status, output ready);
endinterface

### src/psm_cordic.sv
module psm_cordic import psm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cordic_cmd_t          cmd,
	input  logic signed [AW-1:0] x0,
	input  logic signed [AW-1:0] y0,
	input  logic signed [AW-1:0] z0,
	output logic                 done,
	output logic signed [AW-1:0] x,
	output logic signed [AW-1:0] y,
	output logic signed [AW-1:0] z
);

	logic                 busy_q, done_q, vector_q;
	logic [SW-1:0]        step_q;
	logic signed [AW-1:0] x_q, y_q, z_q;
	logic signed [AW-1:0] sx, sy, ang;
	logic                 pos;

	// One micro-rotation per cycle
	always_comb begin
		sx  = y_q >>> step_q;
		sy  = x_q >>> step_q;
		ang = AW'(atan_deg(step_q));
		pos = vector_q ? y_q[AW-1] : ~z_q[AW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			vector_q <= 1'b0;
			step_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
			z_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q   <= 1'b1;
				vector_q <= cmd.vector;
				step_q   <= '0;
				x_q      <= x0;
				y_q      <= y0;
				z_q      <= z0;
			end else if (busy_q) begin
				if (pos) begin
					x_q <= x_q - sx;
					y_q <= y_q + sy;
					z_q <= z_q - ang;
				end else begin
					x_q <= x_q + sx;
					y_q <= y_q - sy;
					z_q <= z_q + ang;
				end
				if (step_q == SW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

### src/psm_muldiv.sv
module psm_muldiv import psm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  md_cmd_t       cmd,
	input  logic [MA-1:0] mul_a,
	input  logic [MB-1:0] mul_b,
	input  logic [NW-1:0] div_n,
	input  logic [DW-1:0] div_d,
	output logic          done,
	output logic [PW-1:0] prod,
	output logic [QW-1:0] quo
);

	logic          busy_q, done_q, div_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] acc_q, a_sh_q;
	logic [MB-1:0] b_q;
	logic [DW:0]   rem_q;
	logic [QW-1:0] low_q, quo_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   trial;
	logic          fits, last;

	// Restoring divide trial and step count
	always_comb begin
		trial = {rem_q[DW-1:0], low_q[QW-1]};
		fits  = trial >= {1'b0, d_q};
		last  = cnt_q == (div_q ? CW'(QW - 1) : CW'(MB - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			a_sh_q <= '0;
			b_q    <= '0;
			rem_q  <= '0;
			low_q  <= '0;
			quo_q  <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				div_q  <= cmd.div;
				cnt_q  <= '0;
				acc_q  <= '0;
				a_sh_q <= PW'(mul_a);
				b_q    <= mul_b;
				rem_q  <= (DW+1)'(div_n[NW-1:QW]);
				low_q  <= div_n[QW-1:0];
				quo_q  <= '0;
				d_q    <= div_d;
			end else if (busy_q) begin
				if (div_q) begin
					// one quotient bit per cycle
					rem_q <= fits ? trial - {1'b0, d_q} : trial;
					quo_q <= {quo_q[QW-2:0], fits};
					low_q <= {low_q[QW-2:0], 1'b0};
				end else begin
					// shift-add, multiplier LSB first
					if (b_q[0])
						acc_q <= acc_q + a_sh_q;
					a_sh_q <= {a_sh_q[PW-2:0], 1'b0};
					b_q    <= {1'b0, b_q[MB-1:1]};
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quo  = quo_q;

endmodule

### src/polar_stereo_map_position_unit.sv
// Polar stereographic map position. Each fix (latitude, longitude, yaw) is
// projected with r = 2*tan(45 - |lat|/2), x = r*sin(lon), y = r*cos(lon),
// turned into Q.16 horizontal and vertical ratios across the configured map
// rectangle, and paired with a heading: yaw + offset when yaw is valid,
// else the atan2 of the ratio change, held when the position did not move.
// One fix is worked at a time; the input is not ready while it runs. The
// next fix can be taken once the result is handed to the output register;
// the handover waits while an earlier result there is still not taken. The
// time is set by one shared 24-step CORDIC (up to three passes: tangent
// angle, longitude, heading) and one shared multiply/divide unit (multiply
// twice, divide up to three times). A steep tangent skips the first
// divide, zero-size bounds skip the two ratio divides, and the heading pass
// runs only when yaw is invalid and the ratios moved. A finished result
// waits in the output register while the next fix is taken. Map registers
// are to be written only while no fix is in flight; the user must keep to
// this, as the block does not enforce it.
module polar_stereo_map_position_unit import psm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [24:0] cfg_data,
	psm_fix_if.sink     fix,
	psm_pos_if.source   pos
);

	typedef enum logic [3:0] {
		S_IDLE, S_ALPHA, S_ROT1, S_TAN, S_DIVT, S_LON, S_ROT2, S_MULX, S_MULY,
		S_RATH, S_RATV, S_RATVW, S_HEAD, S_ATAN, S_DONE
	} state_t;

	state_t state_q;

	// Configuration
	logic               inverse_q;
	logic signed [18:0] tl_x_q, tl_y_q, br_x_q, br_y_q;
	logic signed [24:0] yaw_ofs_q;

	// Latched fix
	logic [23:0]        lat_q;
	logic signed [25:0] lon_q;
	logic signed [24:0] yaw_q;
	logic               yaw_valid_q;

	// Working registers
	logic                 fold_q, neg_q;
	logic signed [AW-1:0] sa_q, ca_q, cl_q, r_q;
	logic signed [UW-1:0] ux_q, uy_q;
	logic signed [19:0]   h_q, v_q, prev_h_q, prev_v_q;
	logic signed [25:0]   head_q;
	logic [1:0]           status_q;

	// Unit operands
	cordic_cmd_t          cor_cmd_q;
	logic signed [AW-1:0] cor_x0_q, cor_y0_q, cor_z0_q;
	logic                 cor_done;
	logic signed [AW-1:0] cor_x, cor_y, cor_z;
	md_cmd_t              md_cmd_q;
	logic [MA-1:0]        mul_a_q;
	logic [MB-1:0]        mul_b_q;
	logic [NW-1:0]        div_n_q;
	logic [DW-1:0]        div_d_q;
	logic                 md_done;
	logic [PW-1:0]        md_prod;
	logic [QW-1:0]        md_quo;

	// Output register
	logic               out_valid_q;
	logic signed [19:0] out_h_q, out_v_q;
	logic signed [25:0] out_head_q;
	logic [1:0]         out_status_q;

	// Combinational helpers
	logic [AW:0]          red_alpha, red_lon;
	logic signed [AW-1:0] sa_fold, ca_fold, sa_abs, cl6, cl6_abs;
	logic signed [AW-1:0] r_abs, r_div;
	logic                 steep;
	logic signed [PW:0]   sprod;
	logic signed [BW-1:0] tlx, tly, brx, bry;
	logic signed [BW:0]   wid, hgt;
	logic [BW:0]          wid_abs, hgt_abs;
	logic signed [UW:0]   num_h, num_v;
	logic [UW:0]          num_h_abs, num_v_abs;
	logic signed [QW:0]   q_sgn;
	logic [20:0]          clip_q;
	logic signed [20:0]   dxs, dys;
	logic signed [AW-1:0] xv, yv;
	logic signed [AW-1:0] z_rnd;
	logic signed [25:0]   yaw_sum;

	always_comb begin
		red_alpha = reduce_angle(DEG45 - AW'({lat_q, 7'b0}));
		red_lon   = reduce_angle({{(AW-26-UP_SHIFT){lon_q[25]}}, lon_q, {UP_SHIFT{1'b0}}});

		sa_fold = fold_q ? -cor_y : cor_y;
		ca_fold = fold_q ? -cor_x : cor_x;
		sa_abs  = sa_q[AW-1] ? -sa_q : sa_q;
		steep   = (ca_q <= 0) || (sa_abs >= (ca_q <<< 3));
		r_div   = neg_q ? -AW'(md_quo) : AW'(md_quo);
		r_abs   = r_q[AW-1] ? -r_q : r_q;

		cl6     = cl_q >>> 6;
		cl6_abs = cl6[AW-1] ? -cl6 : cl6;
		sprod   = neg_q ? -(PW+1)'(md_prod) : (PW+1)'(md_prod);

		tlx = {tl_x_q, {UP_SHIFT{1'b0}}};
		tly = {tl_y_q, {UP_SHIFT{1'b0}}};
		brx = {br_x_q, {UP_SHIFT{1'b0}}};
		bry = {br_y_q, {UP_SHIFT{1'b0}}};
		wid = (BW+1)'(brx) - (BW+1)'(tlx);
		hgt = (BW+1)'(tly) - (BW+1)'(bry);
		wid_abs = wid[BW] ? -wid : wid;
		hgt_abs = hgt[BW] ? -hgt : hgt;
		num_h = (UW+1)'(ux_q) - (UW+1)'(tlx);
		num_v = (UW+1)'(uy_q) - (UW+1)'(bry);
		num_h_abs = num_h[UW] ? -num_h : num_h;
		num_v_abs = num_v[UW] ? -num_v : num_v;

		q_sgn  = neg_q ? -(QW+1)'(md_quo) : (QW+1)'(md_quo);
		clip_q = clip_ratio(q_sgn);

		dxs = 21'(h_q) - 21'(prev_h_q);
		dys = 21'(v_q) - 21'(prev_v_q);
		xv  = {{(AW-29){dxs[20]}}, dxs, 8'b0};
		yv  = {{(AW-29){dys[20]}}, dys, 8'b0};

		z_rnd   = cor_z + AW'(1 << (UP_SHIFT - 1));
		yaw_sum = 26'(yaw_q) + 26'(yaw_ofs_q);
	end

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
			tl_x_q    <= -19'sd131072;
			tl_y_q    <= 19'sd131072;
			br_x_q    <= 19'sd131072;
			br_y_q    <= -19'sd131072;
			yaw_ofs_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_INVERSE: inverse_q <= cfg_data[0];
				REG_TL_X:    tl_x_q    <= cfg_data[18:0];
				REG_TL_Y:    tl_y_q    <= cfg_data[18:0];
				REG_BR_X:    br_x_q    <= cfg_data[18:0];
				REG_BR_Y:    br_y_q    <= cfg_data[18:0];
				REG_YAW_OFS: yaw_ofs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lat_q        <= '0;
			lon_q        <= '0;
			yaw_q        <= '0;
			yaw_valid_q  <= 1'b0;
			fold_q       <= 1'b0;
			neg_q        <= 1'b0;
			sa_q         <= '0;
			ca_q         <= '0;
			cl_q         <= '0;
			r_q          <= '0;
			ux_q         <= '0;
			uy_q         <= '0;
			h_q          <= '0;
			v_q          <= '0;
			prev_h_q     <= '0;
			prev_v_q     <= '0;
			head_q       <= '0;
			status_q     <= ST_OK;
			cor_cmd_q    <= '0;
			cor_x0_q     <= '0;
			cor_y0_q     <= '0;
			cor_z0_q     <= '0;
			md_cmd_q     <= '0;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			div_n_q      <= '0;
			div_d_q      <= '0;
			out_valid_q  <= 1'b0;
			out_h_q      <= '0;
			out_v_q      <= '0;
			out_head_q   <= '0;
			out_status_q <= ST_OK;
		end else begin
			// drop start pulses; a waiting state issues no new start while it waits
			if (cor_cmd_q.start)
				cor_cmd_q.start <= 1'b0;
			if (md_cmd_q.start)
				md_cmd_q.start <= 1'b0;
			if (out_valid_q && pos.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (fix.valid) begin
						lat_q       <= fix.latitude[23] ? 24'(-fix.latitude) : fix.latitude;
						lon_q       <= inverse_q ? -26'(fix.longitude) : 26'(fix.longitude);
						yaw_q       <= fix.yaw;
						yaw_valid_q <= fix.yaw_valid;
						state_q     <= S_ALPHA;
					end
				end
				S_ALPHA: begin
					// rotate by 45 - |lat|/2
					fold_q    <= red_alpha[AW];
					cor_x0_q  <= CORDIC_K;
					cor_y0_q  <= '0;
					cor_z0_q  <= red_alpha[AW-1:0];
					cor_cmd_q <= '{start: 1'b1, vector: 1'b0};
					state_q   <= S_ROT1;
				end
				S_ROT1: begin
					if (cor_done) begin
						sa_q    <= sa_fold;
						ca_q    <= ca_fold;
						state_q <= S_TAN;
					end
				end
				S_TAN: begin
					// saturate steep tangents, else divide sin by cos
					if (steep) begin
						r_q     <= sa_q[AW-1] ? -R_SAT : R_SAT;
						state_q <= S_LON;
					end else begin
						neg_q    <= sa_q[AW-1];
						div_n_q  <= {sa_abs[32:0], 31'b0};
						div_d_q  <= ca_q[DW-1:0];
						md_cmd_q <= '{start: 1'b1, div: 1'b1};
						state_q  <= S_DIVT;
					end
				end
				S_DIVT: begin
					if (md_done) begin
						r_q     <= r_div;
						state_q <= S_LON;
					end
				end
				S_LON: begin
					fold_q    <= red_lon[AW];
					cor_x0_q  <= CORDIC_K;
					cor_y0_q  <= '0;
					cor_z0_q  <= red_lon[AW-1:0];
					cor_cmd_q <= '{start: 1'b1, vector: 1'b0};
					state_q   <= S_ROT2;
				end
				S_ROT2: begin
					if (cor_done) begin
						cl_q     <= ca_fold;
						neg_q    <= r_q[AW-1] ^ sa_fold[AW-1];
						mul_a_q  <= r_abs[MA-1:0];
						mul_b_q  <= MB'(AW'(sa_fold >>> 6) < 0 ?
							-(sa_fold >>> 6) : (sa_fold >>> 6));
						md_cmd_q <= '{start: 1'b1, div: 1'b0};
						state_q  <= S_MULX;
					end
				end
				S_MULX: begin
					if (md_done) begin
						ux_q     <= sprod[PW:30];
						neg_q    <= r_q[AW-1] ^ cl6[AW-1];
						mul_a_q  <= r_abs[MA-1:0];
						mul_b_q  <= cl6_abs[MB-1:0];
						md_cmd_q <= '{start: 1'b1, div: 1'b0};
						state_q  <= S_MULY;
					end
				end
				S_MULY: begin
					if (md_done) begin
						uy_q    <= sprod[PW:30];
						state_q <= S_RATH;
					end
				end
				S_RATH: begin
					// zero-size bounds skip both divides
					if (wid == 0 || hgt == 0) begin
						status_q <= ST_BOUNDS;
						h_q      <= '0;
						v_q      <= '0;
						state_q  <= S_HEAD;
					end else begin
						neg_q    <= num_h[UW] ^ wid[BW];
						div_n_q  <= NW'({num_h_abs, {FRAC_BITS{1'b0}}});
						div_d_q  <= DW'(wid_abs);
						md_cmd_q <= '{start: 1'b1, div: 1'b1};
						state_q  <= S_RATV;
					end
				end
				S_RATV: begin
					if (md_done) begin
						h_q      <= clip_q[19:0];
						status_q <= clip_q[20] ? ST_SAT : ST_OK;
						neg_q    <= num_v[UW] ^ hgt[BW];
						div_n_q  <= NW'({num_v_abs, {FRAC_BITS{1'b0}}});
						div_d_q  <= DW'(hgt_abs);
						md_cmd_q <= '{start: 1'b1, div: 1'b1};
						state_q  <= S_RATVW;
					end
				end
				S_RATVW: begin
					if (md_done) begin
						v_q <= clip_q[19:0];
						if (clip_q[20])
							status_q <= ST_SAT;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (yaw_valid_q) begin
						head_q  <= yaw_sum;
						state_q <= S_DONE;
					end else if (status_q != ST_BOUNDS &&
						(h_q != prev_h_q || v_q != prev_v_q)) begin
						// pre-rotate by 180 degrees for a leftward move
						if (dxs[20]) begin
							cor_x0_q <= -xv;
							cor_y0_q <= -yv;
							cor_z0_q <= dys[20] ? -DEG180 : DEG180;
						end else begin
							cor_x0_q <= xv;
							cor_y0_q <= yv;
							cor_z0_q <= '0;
						end
						cor_cmd_q <= '{start: 1'b1, vector: 1'b1};
						state_q   <= S_ATAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ATAN: begin
					if (cor_done) begin
						head_q  <= z_rnd[UP_SHIFT +: 26];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hand over once the output register is free
					if (!out_valid_q || pos.ready) begin
						out_valid_q  <= 1'b1;
						out_h_q      <= h_q;
						out_v_q      <= v_q;
						out_head_q   <= head_q;
						out_status_q <= status_q;
						if (status_q != ST_BOUNDS) begin
							prev_h_q <= h_q;
							prev_v_q <= v_q;
						end
						state_q <= S_IDLE;
					end else if (out_valid_q && pos.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	psm_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cor_cmd_q),
		.x0     (cor_x0_q),
		.y0     (cor_y0_q),
		.z0     (cor_z0_q),
		.done   (cor_done),
		.x      (cor_x),
		.y      (cor_y),
		.z      (cor_z)
	);

	psm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (md_cmd_q),
		.mul_a  (mul_a_q),
		.mul_b  (mul_b_q),
		.div_n  (div_n_q),
		.div_d  (div_d_q),
		.done   (md_done),
		.prod   (md_prod),
		.quo    (md_quo)
	);

	assign fix.ready   = (state_q == S_IDLE);
	assign pos.valid   = out_valid_q;
	assign pos.h_ratio = out_h_q;
	assign pos.v_ratio = out_v_q;
	assign pos.heading = out_head_q;
	assign pos.status  = out_status_q;

endmodule

### bench/polar_stereo_map_position_unit_tb.sv
`timescale 1ns / 1ps

module polar_stereo_map_position_unit_tb;
	import psm_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd6;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_OFF = 600;
	localparam int TAIL_CYCLES = 400;
	localparam longint D45 = 64'sd754974720;
	localparam longint D90 = 64'sd1509949440;
	localparam longint D180 = 64'sd3019898880;
	localparam longint D360 = 64'sd6039797760;
	localparam longint R_CLIP = 64'sd17179869184;
	localparam longint RMAX = 64'sd524287;

	typedef struct packed {
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		logic signed [24:0] yaw;
		logic yv;
	} fix_t;

	typedef struct packed {
		logic signed [19:0] h;
		logic signed [19:0] v;
		logic signed [25:0] hdg;
		logic [1:0] st;
	} pos_t;

	typedef struct packed {
		logic zb;
		logic typed;
		fix_t f;
		pos_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_index;
	logic [24:0] cfg_data;

	psm_fix_if fix();
	psm_pos_if pos();

	polar_stereo_map_position_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fix(fix),
		.pos(pos)
	);

	// Mirror of the block's registers and history
	longint map_inv, map_tlx, map_tly, map_brx, map_bry, ofs_yaw;
	longint last_h, last_v, last_hdg;
	pos_t expected_pos[$];
	int mismatches = 0;
	int failures = 0;
	int hold_req;
	bit steady;
	int idle_cnt = 0;

	const longint atan_tab[24] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	// Directed fixes: zero-size rows first, with results read off directly
	row_t dir_rows[] = '{
		'{1'b1, 1'b1, '{24'sd0, 25'sd0, 25'sd0, 1'b1}, '{20'sd0, 20'sd0, 26'sd0, ST_BOUNDS}},
		'{1'b1, 1'b1, '{24'sd5898240, 25'sd11796480, 25'sd11796480, 1'b1},
			'{20'sd0, 20'sd0, 26'sd11796480, ST_BOUNDS}},
		'{1'b1, 1'b1, '{-24'sd5898240, -25'sd11796480, -25'sd11796480, 1'b1},
			'{20'sd0, 20'sd0, -26'sd11796480, ST_BOUNDS}},
		'{1'b1, 1'b1, '{24'sd100000, 25'sd2000000, 25'sd77, 1'b0},
			'{20'sd0, 20'sd0, -26'sd11796480, ST_BOUNDS}},
		'{1'b0, 1'b0, '{24'sd0, 25'sd0, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sd0, 25'sd0, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sd5898240, 25'sd0, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{-24'sd5898240, 25'sd5898240, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sh7FFFFF, 25'sd0, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sh800000, 25'sh0FFFFFF, 25'sh0FFFFFF, 1'b1}, '0},
		'{1'b0, 1'b0, '{24'sd1000000, 25'sd11796480, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sd1000000, -25'sd11796480, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sd1000000, -25'sd5898240, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sd1000000, -25'sd5898240, 25'sd0, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sd3000000, 25'sd2949120, -25'sd11796480, 1'b1}, '0},
		'{1'b0, 1'b0, '{-24'sd1, 25'sh1000000, 25'sh1000000, 1'b0}, '0},
		'{1'b0, 1'b0, '{24'sd2000000, 25'sd8847360, 25'sd0, 1'b0}, '0}
	};

	// Rotate a vector of gain 1/K by angle a (degrees Q.24); Q.30 results
	function automatic void sin_cos(input longint a, output longint s, output longint c);
		longint r, x, y, dx, dy;
		bit neg;
		r = a % D360;
		neg = 1'b0;
		x = 64'sd652032874;
		y = 0;
		if (r < 0)
			r += D360;
		if (r >= D180)
			r -= D360;
		if (r > D90) begin
			r -= D180;
			neg = 1'b1;
		end else if (r < -D90) begin
			r += D180;
			neg = 1'b1;
		end
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (r >= 0) begin
				x -= dx;
				y += dy;
				r -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				r += atan_tab[i];
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endfunction

	// Vectoring CORDIC on the ratio change, degrees rounded to Q.16
	function automatic longint heading_of(input longint dy, input longint dx);
		longint x, y, z, sx, sy;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? D180 : -D180;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 24; i++) begin
			sx = y >>> i;
			sy = x >>> i;
			if (y >= 0) begin
				x += sx;
				y -= sy;
				z += atan_tab[i];
			end else begin
				x -= sx;
				y += sy;
				z -= atan_tab[i];
			end
		end
		return (z + 128) >>> 8;
	endfunction

	function automatic longint clip(input longint q, inout bit hit);
		if (q > RMAX) begin
			hit = 1'b1;
			return RMAX;
		end
		if (q < -RMAX) begin
			hit = 1'b1;
			return -RMAX;
		end
		return q;
	endfunction

	// Project one fix onto the map and advance the heading history
	function automatic pos_t project_fix(input fix_t f);
		longint lat, lon, alpha, sa, ca, sl, cl, r, ux, uy;
		longint tlx, tly, brx, bry, wid, hgt, h, v, abs_s;
		bit hit;
		pos_t p;
		lat = f.lat;
		lon = f.lon;
		h = 0;
		v = 0;
		hit = 1'b0;
		if (lat < 0)
			lat = -lat;
		if (map_inv != 0)
			lon = -lon;
		alpha = D45 - ((lat * 256) >>> 1);
		sin_cos(alpha, sa, ca);
		abs_s = (sa < 0) ? -sa : sa;
		if (ca <= 0 || abs_s >= 8 * ca)
			r = (sa < 0) ? -R_CLIP : R_CLIP;
		else
			r = (sa * 64'sd2147483648) / ca;
		sin_cos(lon * 256, sl, cl);
		ux = (r * (sl >>> 6)) >>> 30;
		uy = (r * (cl >>> 6)) >>> 30;
		tlx = map_tlx * 256;
		tly = map_tly * 256;
		brx = map_brx * 256;
		bry = map_bry * 256;
		wid = brx - tlx;
		hgt = tly - bry;
		if (wid == 0 || hgt == 0) begin
			p.st = ST_BOUNDS;
		end else begin
			h = clip(((ux - tlx) * 65536) / wid, hit);
			v = clip(((uy - bry) * 65536) / hgt, hit);
			p.st = hit ? ST_SAT : ST_OK;
		end
		if (f.yv)
			last_hdg = longint'(f.yaw) + ofs_yaw;
		else if (p.st != ST_BOUNDS && (h != last_h || v != last_v))
			last_hdg = heading_of(v - last_v, h - last_h);
		if (p.st != ST_BOUNDS) begin
			last_h = h;
			last_v = v;
		end
		p.h = h[19:0];
		p.v = v[19:0];
		p.hdg = last_hdg[25:0];
		return p;
	endfunction

	// Clock
	always #5 clk = ~clk;

	// Watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((fix.valid && fix.ready) || (pos.valid && pos.ready) || !arst_n)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side: stall at random, hold off on request, check each transaction
	initial begin
		pos_t want;
		pos_t got;
		int gap;
		int hold_seen;
		pos.ready = 1'b0;
		hold_seen = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 13);
			if (hold_req != hold_seen) begin
				gap = HOLD_OFF;
				hold_seen = hold_req;
			end
			if (gap > 0) begin
				pos.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pos.ready <= 1'b1;
			@(posedge clk);
			while (!pos.valid)
				@(posedge clk);
			got = '{pos.h_ratio, pos.v_ratio, pos.heading, pos.status};
			if (expected_pos.size() == 0) begin
				failures++;
				$display("result with nothing expected: h=%0d v=%0d hdg=%0d st=%0d",
					got.h, got.v, got.hdg, got.st);
			end else begin
				want = expected_pos.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp h=%0d v=%0d hdg=%0d st=%0d, got h=%0d v=%0d hdg=%0d st=%0d",
							want.h, want.v, want.hdg, want.st,
							got.h, got.v, got.hdg, got.st);
				end
			end
		end
	end

	// Offer one fix, then record its expected position
	task automatic send_fix(input fix_t f, input bit typed, input pos_t e);
		int gap;
		pos_t p;
		gap = steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			fix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		fix.valid <= 1'b1;
		fix.latitude <= f.lat;
		fix.longitude <= f.lon;
		fix.yaw <= f.yaw;
		fix.yaw_valid <= f.yv;
		@(posedge clk);
		while (!fix.ready)
			@(posedge clk);
		p = project_fix(f);
		expected_pos.insert(expected_pos.size(), typed ? e : p);
	endtask

	// Lower valid and wait until every expected position has come back
	task automatic drain();
		fix.valid <= 1'b0;
		while (expected_pos.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic cfg_set(input logic [2:0] idx, input int val);
		logic [24:0] d;
		d = val[24:0];
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_INVERSE: map_inv = d[0];
			REG_TL_X: map_tlx = $signed(d[18:0]);
			REG_TL_Y: map_tly = $signed(d[18:0]);
			REG_BR_X: map_brx = $signed(d[18:0]);
			REG_BR_Y: map_bry = $signed(d[18:0]);
			REG_YAW_OFS: ofs_yaw = $signed(d[24:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_map(input int inv, input int tlx, input int tly,
			input int brx, input int bry, input int ofs);
		cfg_set(REG_INVERSE, inv);
		cfg_set(REG_TL_X, tlx);
		cfg_set(REG_TL_Y, tly);
		cfg_set(REG_BR_X, brx);
		cfg_set(REG_BR_Y, bry);
		cfg_set(REG_YAW_OFS, ofs);
	endtask

	function automatic int rand_bound();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 262144) - 131072;
			1: return $urandom_range(0, 16384) - 8192;
			2: return $urandom_range(0, 1) ? 131072 : -131072;
			default: return $urandom();
		endcase
	endfunction

	// Draw a fix: mostly in range, some raw patterns, some repeats
	function automatic fix_t rand_fix(input fix_t prev);
		fix_t f;
		int sel;
		sel = $urandom_range(0, 99);
		f.lat = $urandom_range(0, 11796480) - 5898240;
		if (sel < 15)
			f.lat = $urandom_range(0, 1) ? 5898240 - $urandom_range(0, 300000)
				: $urandom_range(0, 300000) - 5898240;
		f.lon = $urandom_range(0, 23592960) - 11796480;
		f.yaw = $urandom_range(0, 23592960) - 11796480;
		f.yv = ($urandom_range(0, 2) == 0);
		if (sel >= 80 && sel < 90) begin
			f.lat = $urandom();
			f.lon = $urandom();
			f.yaw = $urandom();
		end else if (sel >= 90) begin
			f = prev;
			f.yv = 1'b0;
		end
		return f;
	endfunction

	// Main sequence
	initial begin
		fix_t f;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_INVERSE;
		cfg_data = '0;
		fix.valid = 1'b0;
		fix.latitude = '0;
		fix.longitude = '0;
		fix.yaw = '0;
		fix.yaw_valid = 1'b0;
		map_inv = 0;
		map_tlx = -131072;
		map_tly = 131072;
		map_brx = 131072;
		map_bry = -131072;
		ofs_yaw = 0;
		last_h = 0;
		last_v = 0;
		last_hdg = 0;
		hold_req = 0;
		steady = 1'b0;
		f = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero-width map first, then the reset map
		cfg_set(REG_TL_X, 131072);
		foreach (dir_rows[i]) begin
			if (!dir_rows[i].zb && dir_rows[i - 1].zb) begin
				drain();
				cfg_map(0, -131072, 131072, 131072, -131072, 0);
			end
			send_fix(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].e);
		end
		drain();

		// Random phases over several map settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: cfg_map(1, -131072, 131072, 131072, -131072, 11796480);
				1: cfg_map(0, -4096, 4096, 4096, -4096, -11796480);
				2: cfg_map(1, 131072, -131072, -131072, 131072, 0);
				3: cfg_map(0, -65536, 70000, 65536, 70000, 123456);
				4: cfg_map(0, -131072, 131072, -131072, -131072, 0);
				default: cfg_map($urandom(), rand_bound(), rand_bound(),
					rand_bound(), rand_bound(), $urandom());
			endcase
			if (ph == 5)
				cfg_set(REG_SPARE, $urandom());
			if (ph == 1)
				hold_req = hold_req + 1;
			for (int n = 0; n < 230; n++) begin
				steady = ((n / 40) % 4 == 2);
				f = rand_fix(f);
				send_fix(f, 1'b0, '0);
			end
			steady = 1'b0;
			drain();
		end

		// Let any stray result show up, then report
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && failures == 0 && expected_pos.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
